FILE: rtl/h264aus_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// h264aus_pkg
// shared types and constants for the annex b access unit splitter
// ----------------------------------------------------------------------------
package h264aus_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned EVENT_W = 2;
	localparam int unsigned OUT_W   = 40;

	localparam logic [4:0] NAL_SLICE     = 5'd1;
	localparam logic [4:0] NAL_IDR_SLICE = 5'd5;
	localparam logic [4:0] NAL_SEI       = 5'd6;
	localparam logic [4:0] NAL_SPS       = 5'd7;
	localparam logic [4:0] NAL_PPS       = 5'd8;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE     = 2'd0,
		EV_FIRST    = 2'd1,
		EV_BOUNDARY = 2'd2
	} event_t;

	typedef enum logic [5:0] {
		SC_NONE  = 6'b000001,
		SC_ZERO1 = 6'b000010,
		SC_ZERO2 = 6'b000100,
		SC_ZERO3 = 6'b001000,
		SC_CODE  = 6'b010000,
		SC_SLICE = 6'b100000
	} scan_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/h264_access_unit_splitter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// h264_access_unit_splitter_core
// byte-wide annex b start code parser reporting access unit boundaries
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the slave side unless stalled and gives one
// word per byte on the master side: the byte is caught in an input register,
// then the start code scanner and unit counters update in a single pass as
// the result word is loaded into the output register. Both registers can
// hold a word, so the input keeps accepting for one more byte while a result
// is stalled. No clearing pass follows reset. header_only_mode is written by
// the user through the cfg channel only while the block is idle, unenforced;
// when set, the first unit ends at the first picture after headers.
module h264_access_unit_splitter_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic                           cfg_data,       // header_only_mode
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [h264aus_pkg::BYTE_W-1:0] s_axis_tdata,   // data_byte
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [h264aus_pkg::OUT_W-1:0]       m_axis_tdata    // event_res, start_code_position
);

	logic                             header_only_q;
	logic                             valid_s1;
	logic [h264aus_pkg::BYTE_W-1:0]   byte_s1;
	logic                             out_valid_q;
	h264aus_pkg::event_t              out_event_q;
	logic [h264aus_pkg::POS_W-1:0]    out_pos_q;

	h264aus_pkg::scan_state_t         scan_q, scan_d;
	logic                             last_slice_q, last_slice_d;
	logic [h264aus_pkg::CNT_W-1:0]    hdr_cnt_q, hdr_cnt_d;
	logic [h264aus_pkg::CNT_W-1:0]    pic_cnt_q, pic_cnt_d;
	logic [h264aus_pkg::POS_W-1:0]    cand_pos_q, cand_pos_d;
	logic                             start_found_q, start_found_d;
	logic                             await_end_q, await_end_d;
	logic [h264aus_pkg::POS_W-1:0]    byte_pos_q;
	h264aus_pkg::event_t              event_d;
	logic [h264aus_pkg::POS_W-1:0]    pos_d;

	logic                             out_free;
	logic                             adv_s2;
	logic [4:0]                       nal_type;

	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s2        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign nal_type      = byte_s1[4:0];

	always_comb begin
		scan_d        = scan_q;
		last_slice_d  = last_slice_q;
		hdr_cnt_d     = hdr_cnt_q;
		pic_cnt_d     = pic_cnt_q;
		cand_pos_d    = cand_pos_q;
		start_found_d = start_found_q;
		await_end_d   = await_end_q;
		event_d       = h264aus_pkg::EV_NONE;
		pos_d         = '0;

		// start code scanner
		unique case (scan_q)
			h264aus_pkg::SC_NONE: begin
				if (byte_s1 == 8'h00) begin
					scan_d     = h264aus_pkg::SC_ZERO1;
					cand_pos_d = byte_pos_q;
				end
			end
			h264aus_pkg::SC_ZERO1: begin
				scan_d = (byte_s1 == 8'h00) ? h264aus_pkg::SC_ZERO2 : h264aus_pkg::SC_NONE;
			end
			h264aus_pkg::SC_ZERO2: begin
				if (byte_s1 == 8'h01) scan_d = h264aus_pkg::SC_CODE;
				else if (byte_s1 == 8'h00) scan_d = h264aus_pkg::SC_ZERO3;
				else scan_d = h264aus_pkg::SC_NONE;
			end
			h264aus_pkg::SC_ZERO3: begin
				// long zero run keeps only its last three zeros
				if (byte_s1 == 8'h01) scan_d = h264aus_pkg::SC_CODE;
				else if (byte_s1 == 8'h00) cand_pos_d = cand_pos_q + 32'd1;
				else scan_d = h264aus_pkg::SC_NONE;
			end
			h264aus_pkg::SC_CODE: begin
				if (nal_type == h264aus_pkg::NAL_SLICE || nal_type == h264aus_pkg::NAL_IDR_SLICE) begin
					scan_d = h264aus_pkg::SC_SLICE;
				end else begin
					scan_d = h264aus_pkg::SC_NONE;
					if (nal_type == h264aus_pkg::NAL_SEI || nal_type == h264aus_pkg::NAL_SPS ||
					    nal_type == h264aus_pkg::NAL_PPS) begin
						last_slice_d = 1'b0;
						hdr_cnt_d    = h264aus_pkg::sat_inc(hdr_cnt_q);
					end
				end
			end
			h264aus_pkg::SC_SLICE: begin
				// first_mb_in_slice zero marks a new picture
				if (byte_s1[7]) begin
					pic_cnt_d    = h264aus_pkg::sat_inc(pic_cnt_q);
					last_slice_d = 1'b1;
				end
				scan_d = h264aus_pkg::SC_NONE;
			end
			default: scan_d = h264aus_pkg::SC_NONE;
		endcase

		// unit bookkeeping, order matters
		if (header_only_q && hdr_cnt_d != '0 && pic_cnt_d == 8'd1) begin
			event_d       = h264aus_pkg::EV_BOUNDARY;
			pos_d         = cand_pos_d;
			start_found_d = 1'b1;
			pic_cnt_d     = '0;
			await_end_d   = last_slice_d;
			hdr_cnt_d     = last_slice_d ? 8'd0 : 8'd1;
		end else begin
			if (!start_found_d && hdr_cnt_d == 8'd1 && pic_cnt_d == '0) begin
				start_found_d = 1'b1;
				event_d       = h264aus_pkg::EV_FIRST;
				pos_d         = cand_pos_d;
			end
			if (!start_found_d && hdr_cnt_d == '0 && pic_cnt_d == 8'd1) begin
				start_found_d = 1'b1;
				await_end_d   = 1'b1;
				hdr_cnt_d     = '0;
				pic_cnt_d     = '0;
				event_d       = h264aus_pkg::EV_FIRST;
				pos_d         = cand_pos_d;
			end
			if (!await_end_d && hdr_cnt_d != '0 && pic_cnt_d == 8'd1) begin
				await_end_d = 1'b1;
				hdr_cnt_d   = '0;
				pic_cnt_d   = '0;
			end
			if (await_end_d && (hdr_cnt_d != '0 || pic_cnt_d != '0)) begin
				event_d       = h264aus_pkg::EV_BOUNDARY;
				pos_d         = cand_pos_d;
				start_found_d = 1'b1;
				pic_cnt_d     = '0;
				await_end_d   = last_slice_d;
				hdr_cnt_d     = last_slice_d ? 8'd0 : 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			header_only_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q        <= h264aus_pkg::SC_NONE;
			last_slice_q  <= 1'b0;
			hdr_cnt_q     <= '0;
			pic_cnt_q     <= '0;
			cand_pos_q    <= '0;
			start_found_q <= 1'b0;
			await_end_q   <= 1'b0;
			byte_pos_q    <= '0;
		end else if (adv_s2) begin
			scan_q        <= scan_d;
			last_slice_q  <= last_slice_d;
			hdr_cnt_q     <= hdr_cnt_d;
			pic_cnt_q     <= pic_cnt_d;
			cand_pos_q    <= cand_pos_d;
			start_found_q <= start_found_d;
			await_end_q   <= await_end_d;
			byte_pos_q    <= byte_pos_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_event_q <= event_d;
			out_pos_q   <= pos_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_pos_q, out_event_q};

	// a word without an event carries no position
	a_pos_zero_without_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_event_q == h264aus_pkg::EV_NONE |-> out_pos_q == '0)
		else $error("position set on a word without an event");

	// once the first unit start is found it stays found
	a_start_found_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(start_found_q))
		else $error("start_found cleared");

	// a first start word is only produced before the start was found
	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && event_d == h264aus_pkg::EV_FIRST |-> !start_found_q)
		else $error("second first-start event");

	// stalled output keeps the byte counter still
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> $stable(byte_pos_q))
		else $error("state advanced while output stalled");

endmodule
`default_nettype wire

FILE: test/h264_access_unit_splitter_core_tb.sv
// ----------------------------------------------------------------------------
// h264_access_unit_splitter_core_tb
// self-checking bench for the annex b access unit splitter
// ----------------------------------------------------------------------------
// Streams bytes into the splitter and checks every result word against an
// in-bench model of the start code scanner and unit counters (typed table
// rows bring their own result). A short table of hand-picked bytes comes
// first. Random start-code framed nal units in both header modes follow,
// with a run of back to back headers in between. Both stream sides idle at
// random. One long output stall lets the block back up onto its input.
// ----------------------------------------------------------------------------
module h264_access_unit_splitter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 500;
	localparam int unsigned HOLD_CYCLES    = 60;
	localparam logic [7:0]  START_TAIL     = 8'h01;

	typedef struct packed {
		h264aus_pkg::event_t ev;
		logic [31:0]         pos;
	} unit_event_t;

	typedef struct packed {
		logic [7:0]          b;
		logic                typed;
		h264aus_pkg::event_t ev;
		logic [31:0]         pos;
	} stim_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_data      = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        m_axis_tready = 1'b0;
	wire logic   cfg_ready;
	wire logic   s_axis_tready;
	wire logic   m_axis_tvalid;
	wire logic [h264aus_pkg::OUT_W-1:0] m_axis_tdata;   // event_res, start_code_position

	// model state
	h264aus_pkg::scan_state_t scan = h264aus_pkg::SC_NONE;
	logic        last_slice = 1'b0;
	logic [7:0]  hdr_cnt    = '0;
	logic [7:0]  pic_cnt    = '0;
	logic [31:0] cand_pos   = '0;
	logic        start_seen = 1'b0;
	logic        await_end  = 1'b0;
	logic [31:0] byte_pos   = '0;
	logic        hdr_only   = 1'b0;

	unit_event_t pending_events[$];
	int          mismatches   = 0;
	int          bytes_sent   = 0;
	int          words_seen   = 0;
	int unsigned idle_cycles  = 0;
	bit          no_idle      = 1'b0;
	bit          hold_request = 1'b0;

	// a header run, an idr picture, a slice picture closing the unit, nal type 0
	stim_row_t directed_rows [25] = '{
		'{8'h00, 1'b1, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h01, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h67, 1'b1, h264aus_pkg::EV_FIRST, 32'd1},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h01, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h68, 1'b1, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h01, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h65, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h88, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'hFF, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h01, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h41, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h80, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h00, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'h01, 1'b0, h264aus_pkg::EV_NONE,  32'd0},
		'{8'hE0, 1'b0, h264aus_pkg::EV_NONE,  32'd0}
	};

	h264_access_unit_splitter_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] bump(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic void end_unit();
		start_seen = 1'b1;
		pic_cnt    = '0;
		if (last_slice) begin
			await_end = 1'b1;
			hdr_cnt   = '0;
		end else begin
			await_end = 1'b0;
			hdr_cnt   = 8'd1;
		end
	endfunction

	function automatic unit_event_t split_step(input logic [7:0] b);
		unit_event_t r;
		logic [4:0]  t;
		r.ev  = h264aus_pkg::EV_NONE;
		r.pos = '0;
		t     = b[4:0];
		case (scan)
			h264aus_pkg::SC_NONE: begin
				if (b == 8'h00) begin
					scan     = h264aus_pkg::SC_ZERO1;
					cand_pos = byte_pos;
				end
			end
			h264aus_pkg::SC_ZERO1:
				scan = (b == 8'h00) ? h264aus_pkg::SC_ZERO2 : h264aus_pkg::SC_NONE;
			h264aus_pkg::SC_ZERO2: begin
				if (b == START_TAIL)
					scan = h264aus_pkg::SC_CODE;
				else if (b == 8'h00)
					scan = h264aus_pkg::SC_ZERO3;
				else
					scan = h264aus_pkg::SC_NONE;
			end
			h264aus_pkg::SC_ZERO3: begin
				// longer zero runs keep only the last three zeros
				if (b == START_TAIL)
					scan = h264aus_pkg::SC_CODE;
				else if (b == 8'h00)
					cand_pos = cand_pos + 32'd1;
				else
					scan = h264aus_pkg::SC_NONE;
			end
			h264aus_pkg::SC_CODE: begin
				if (t == h264aus_pkg::NAL_SLICE || t == h264aus_pkg::NAL_IDR_SLICE) begin
					scan = h264aus_pkg::SC_SLICE;
				end else begin
					scan = h264aus_pkg::SC_NONE;
					if (t == h264aus_pkg::NAL_SEI || t == h264aus_pkg::NAL_SPS ||
							t == h264aus_pkg::NAL_PPS) begin
						last_slice = 1'b0;
						hdr_cnt    = bump(hdr_cnt);
					end
				end
			end
			h264aus_pkg::SC_SLICE: begin
				// first bit of the slice header set means a new picture
				if (b[7]) begin
					pic_cnt    = bump(pic_cnt);
					last_slice = 1'b1;
				end
				scan = h264aus_pkg::SC_NONE;
			end
			default: scan = h264aus_pkg::SC_NONE;
		endcase

		if (hdr_only && hdr_cnt >= 8'd1 && pic_cnt == 8'd1) begin
			r.ev  = h264aus_pkg::EV_BOUNDARY;
			r.pos = cand_pos;
			end_unit();
		end else begin
			if (!start_seen && hdr_cnt == 8'd1 && pic_cnt == 8'd0) begin
				start_seen = 1'b1;
				r.ev       = h264aus_pkg::EV_FIRST;
				r.pos      = cand_pos;
			end
			if (!start_seen && hdr_cnt == 8'd0 && pic_cnt == 8'd1) begin
				start_seen = 1'b1;
				await_end  = 1'b1;
				hdr_cnt    = '0;
				pic_cnt    = '0;
				r.ev       = h264aus_pkg::EV_FIRST;
				r.pos      = cand_pos;
			end
			if (!await_end && hdr_cnt != 8'd0 && pic_cnt == 8'd1) begin
				await_end = 1'b1;
				hdr_cnt   = '0;
				pic_cnt   = '0;
			end
			if (await_end && (hdr_cnt != 8'd0 || pic_cnt != 8'd0)) begin
				r.ev  = h264aus_pkg::EV_BOUNDARY;
				r.pos = cand_pos;
				end_unit();
			end
		end
		byte_pos = byte_pos + 32'd1;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s in word %0d: got %0h, expected %0h",
			$realtime, what, words_seen, got, want);
		mismatches++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic typed,
			input h264aus_pkg::event_t t_ev, input logic [31:0] t_pos);
		int          gap;
		unit_event_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		predicted = split_step(b);
		if (typed) begin
			predicted.ev  = t_ev;
			predicted.pos = t_pos;
		end
		pending_events.push_back(predicted);
		bytes_sent++;
	endtask

	task automatic send(input logic [7:0] b);
		send_byte(b, 1'b0, h264aus_pkg::EV_NONE, '0);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		hdr_only  = m;
	endtask

	// one nal unit behind a start code, mostly well formed
	task automatic send_random_unit();
		logic [7:0] nal;
		logic [7:0] b;
		int         pick;
		if ($urandom_range(0, 7) == 0)
			no_idle = !no_idle;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// broken start code
			repeat ($urandom_range(1, 3)) send(8'h00);
			send(8'($urandom_range(2, 255)));
		end else begin
			repeat ($urandom_range(2, 5)) send(8'h00);
			send(START_TAIL);
			nal  = 8'($urandom());
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				nal[4:0] = ($urandom_range(0, 1) == 0) ? h264aus_pkg::NAL_SLICE
					: h264aus_pkg::NAL_IDR_SLICE;
			end else if (pick < 8) begin
				case ($urandom_range(0, 2))
					0:       nal[4:0] = h264aus_pkg::NAL_SEI;
					1:       nal[4:0] = h264aus_pkg::NAL_SPS;
					default: nal[4:0] = h264aus_pkg::NAL_PPS;
				endcase
			end
			send(nal);
			if (nal[4:0] == h264aus_pkg::NAL_SLICE || nal[4:0] == h264aus_pkg::NAL_IDR_SLICE) begin
				b = 8'($urandom());
				if ($urandom_range(0, 9) < 7)
					b[7] = 1'b1;
				send(b);
			end
		end
		repeat ($urandom_range(0, 4)) send(8'($urandom()));
	endtask

	task automatic random_phase(input int n_bytes, input bit with_hold);
		int stop_at;
		int hold_at;
		stop_at = bytes_sent + n_bytes;
		hold_at = bytes_sent + n_bytes / 2;
		while (bytes_sent < stop_at) begin
			if (with_hold && bytes_sent >= hold_at) begin
				hold_request = 1'b1;
				with_hold    = 1'b0;
			end
			send_random_unit();
		end
		no_idle = 1'b0;
		drain_results();
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(1'b0);
		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].ev,
				directed_rows[i].pos);
		drain_results();

		write_mode(1'b1);
		random_phase(75, 1'b1);

		// run of headers with no picture between them
		write_mode(1'b0);
		repeat (20) begin
			send(8'h00);
			send(8'h00);
			send(START_TAIL);
			send(8'h67);
		end
		random_phase(75, 1'b0);

		write_mode(1'b1);
		random_phase(75, 1'b0);

		write_mode(1'b0);
		random_phase(75, 1'b0);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : sink
		int wait_cycles;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			wait_cycles = no_idle ? 0 : $urandom_range(0, 3);
			if (wait_cycles != 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		unit_event_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata[33:2], '0);
			end else begin
				want = pending_events.pop_front();
				if (m_axis_tdata[1:0] !== want.ev)
					report_mismatch("event_res", 32'(m_axis_tdata[1:0]), 32'(want.ev));
				if (m_axis_tdata[33:2] !== want.pos)
					report_mismatch("start_code_position", m_axis_tdata[33:2], want.pos);
			end
			words_seen++;
		end
	end

	// stall guard: no word moving on any channel for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

FILE: sim.f
rtl/h264aus_pkg.sv
rtl/h264_access_unit_splitter_core.sv
test/h264_access_unit_splitter_core_tb.sv
